### hw/rtl/vcdm_pkg.sv
// Shared types, constants and scaling tables for the vertex color decoder.
// Depends on nothing; every other file of the block but vcdm_stream_if imports it.
package vcdm_pkg;

	// Default depth of the morph blend.
	localparam int MAX_MORPH_TARGETS_DEF = 8;

	// Configuration port geometry.
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;

	// Scaled channel (unsigned 8.8) times weight (signed Q4.12) gives a signed Q.20 product.
	localparam int PROD_W     = 33;
	localparam int FRAC_SHIFT = 20;

	localparam logic [15:0] FULL_SCALE_88 = 16'hFF00;
	localparam logic [7:0]  OPAQUE        = 8'hFF;

	// Full-scale codes of the narrow channel fields.
	localparam int MAX5 = 31;
	localparam int MAX6 = 63;
	localparam int MAX4 = 15;

	typedef enum logic [1:0] {
		FMT_RGB565   = 2'd0,
		FMT_RGBA5551 = 2'd1,
		FMT_RGBA4444 = 2'd2,
		FMT_RGBA8888 = 2'd3
	} color_fmt_t;

	typedef enum logic {
		REG_COLOR_FORMAT = 1'b0,
		REG_MORPH_COUNT  = 1'b1
	} reg_index_t;

	typedef struct packed {
		color_fmt_t  color_format;
		logic [3:0]  morph_count;
	} cfg_t;

	typedef struct packed {
		logic [31:0]        color_word;
		logic signed [15:0] morph_weight;
		logic               new_batch;
	} color_in_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       full_alpha;
	} color_out_t;

	// Decoded target as it leaves the decode stage; index 0 is red, 3 is alpha.
	typedef struct packed {
		logic                        fmt565;
		logic                        new_batch;
		logic [3:0][7:0]             expanded;
		logic [3:0][PROD_W-1:0]      product;
	} decode_s2_t;

	typedef logic [15:0] scale5_tab_t [32];
	typedef logic [15:0] scale6_tab_t [64];
	typedef logic [15:0] scale4_tab_t [16];

	// Rounded 8.8 scale of a field: round(v * 255 * 256 / full scale), halves up.
	function automatic scale5_tab_t build_scale5();
		scale5_tab_t t;
		for (int i = 0; i < 32; i++) begin
			t[i] = 16'((i * 65280 + MAX5 / 2) / MAX5);
		end
		return t;
	endfunction

	function automatic scale6_tab_t build_scale6();
		scale6_tab_t t;
		for (int i = 0; i < 64; i++) begin
			t[i] = 16'((i * 65280 + MAX6 / 2) / MAX6);
		end
		return t;
	endfunction

	function automatic scale4_tab_t build_scale4();
		scale4_tab_t t;
		for (int i = 0; i < 16; i++) begin
			t[i] = 16'((i * 65280 + MAX4 / 2) / MAX4);
		end
		return t;
	endfunction

	localparam scale5_tab_t SCALE5 = build_scale5();
	localparam scale6_tab_t SCALE6 = build_scale6();
	localparam scale4_tab_t SCALE4 = build_scale4();

endpackage

### hw/rtl/vcdm_stream_if.sv
// Valid/ready stream channel used for the color input and the result output.
// The payload type is set per instance; no package dependency.
interface vcdm_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/vertex_color_decode_morph.sv
// Vertex color decoder with morph-target blending: top level.
// Depends on vcdm_pkg, vcdm_stream_if, vcdm_cfg, vcdm_decode and vcdm_accum.
//
// color_in carries one packed color word per morph target with its signed
// Q4.12 weight and a new_batch mark; color_out carries one RGBA8888 result
// per vertex together with the sticky full_alpha flag. Both are valid/ready
// channels; a transfer happens on a clock edge with valid and ready high.
// The APB port sets the color format and the morph count; any write drops a
// vertex that is only partly blended. Write only while the block is idle.
//
// The last target of a vertex passes the input register, the decode
// register and the output register before its result is offered on
// color_out. One target is taken every cycle unless a finished result
// waits for a stalled receiver. The four channel multipliers and the
// accumulate adders set the cycle.
//
// Reset clears the pipeline, the counts and sums and sets full_alpha. When
// the receiver stalls, the result holds in the output register and the
// pipeline keeps taking targets until the next finished target waits for
// the output slot and the input register behind it is full; then color_in.ready drops.
module vertex_color_decode_morph
	import vcdm_pkg::*;
#(
	parameter int MAX_MORPH_TARGETS = MAX_MORPH_TARGETS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	vcdm_stream_if.sink           color_in,
	vcdm_stream_if.source         color_out,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	cfg_t       cfg;
	logic       vertex_clear;
	logic       s2_valid;
	logic       s2_ready;
	decode_s2_t s2_data;

	// Configuration registers.
	vcdm_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.cfg          (cfg),
		.vertex_clear (vertex_clear)
	);

	// Input register, channel decode and weighting.
	vcdm_decode u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.color_in     (color_in),
		.color_format (cfg.color_format),
		.s2_ready     (s2_ready),
		.s2_valid     (s2_valid),
		.s2_data      (s2_data)
	);

	// Blend accumulation and result register.
	vcdm_accum #(
		.MAX_MORPH_TARGETS (MAX_MORPH_TARGETS)
	) u_accum (
		.clk          (clk),
		.arst_n       (arst_n),
		.morph_count  (cfg.morph_count),
		.vertex_clear (vertex_clear),
		.s2_valid     (s2_valid),
		.s2_data      (s2_data),
		.s2_ready     (s2_ready),
		.color_out    (color_out)
	);

endmodule

### hw/rtl/vcdm_cfg.sv
// APB-style configuration registers: color format and morph count.
// Depends on vcdm_pkg.
module vcdm_cfg
	import vcdm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg,
	output logic                  vertex_clear
);

	cfg_t       cfg_q;
	reg_index_t reg_idx;
	logic       wr_en;

	// Registers sit at word addresses; the word index picks the register.
	assign reg_idx = reg_index_t'(paddr[2]);
	assign wr_en   = psel & penable & pwrite;
	assign pready  = 1'b1;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.color_format <= FMT_RGB565;
			cfg_q.morph_count  <= 4'd1;
		end else if (wr_en) begin
			case (reg_idx)
				REG_COLOR_FORMAT: cfg_q.color_format <= color_fmt_t'(pwdata[1:0]);
				REG_MORPH_COUNT:  cfg_q.morph_count  <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	// Read-back mux.
	always_comb begin
		case (reg_idx)
			REG_COLOR_FORMAT: prdata = CFG_DATA_W'(cfg_q.color_format);
			REG_MORPH_COUNT:  prdata = CFG_DATA_W'(cfg_q.morph_count);
			default:          prdata = '0;
		endcase
	end

	// Every write drops a partly blended vertex.
	assign vertex_clear = wr_en;
	assign cfg          = cfg_q;

endmodule

### hw/rtl/vcdm_decode.sv
// Input register and decode stage: splits the packed word, expands and scales
// each channel and forms the weighted products. Depends on vcdm_pkg and vcdm_stream_if.
module vcdm_decode
	import vcdm_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	vcdm_stream_if.sink    color_in,
	input  color_fmt_t     color_format,
	input  logic           s2_ready,
	output logic           s2_valid,
	output decode_s2_t     s2_data
);

	logic        valid_s1;
	color_in_t   item_s1;
	logic        accept_s1;
	logic        valid_s2;
	decode_s2_t  data_s2;
	decode_s2_t  dec_c;

	// Stage 1 loads whenever it is empty or its item moves on.
	assign accept_s1      = !valid_s1 || s2_ready;
	assign color_in.ready = accept_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept_s1) begin
				valid_s1 <= color_in.valid;
			end
			if (s2_ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept_s1 && color_in.valid) begin
			item_s1 <= color_in.payload;
		end
		if (s2_ready && valid_s1) begin
			data_s2 <= dec_c;
		end
	end

	// Field split, bit-replicated expansion and 8.8 scaling per format.
	always_comb begin
		logic [31:0]             w;
		logic [3:0][15:0]        scaled;
		logic signed [PROD_W-1:0] sc_ext;
		logic signed [PROD_W-1:0] wt_ext;
		logic signed [PROD_W-1:0] prod;
		w      = item_s1.color_word;
		scaled = '0;
		dec_c  = '0;
		dec_c.fmt565    = (color_format == FMT_RGB565);
		dec_c.new_batch = item_s1.new_batch;
		case (color_format)
			FMT_RGB565: begin
				dec_c.expanded[0] = {w[4:0], w[4:2]};
				dec_c.expanded[1] = {w[10:5], w[10:9]};
				dec_c.expanded[2] = {w[15:11], w[15:13]};
				dec_c.expanded[3] = OPAQUE;
				scaled[0] = SCALE5[w[4:0]];
				scaled[1] = SCALE6[w[10:5]];
				scaled[2] = SCALE5[w[15:11]];
				scaled[3] = FULL_SCALE_88;
			end
			FMT_RGBA5551: begin
				dec_c.expanded[0] = {w[4:0], w[4:2]};
				dec_c.expanded[1] = {w[9:5], w[9:7]};
				dec_c.expanded[2] = {w[14:10], w[14:12]};
				dec_c.expanded[3] = w[15] ? OPAQUE : 8'h00;
				scaled[0] = SCALE5[w[4:0]];
				scaled[1] = SCALE5[w[9:5]];
				scaled[2] = SCALE5[w[14:10]];
				scaled[3] = w[15] ? FULL_SCALE_88 : 16'h0000;
			end
			FMT_RGBA4444: begin
				dec_c.expanded[0] = {w[3:0], w[3:0]};
				dec_c.expanded[1] = {w[7:4], w[7:4]};
				dec_c.expanded[2] = {w[11:8], w[11:8]};
				dec_c.expanded[3] = {w[15:12], w[15:12]};
				scaled[0] = SCALE4[w[3:0]];
				scaled[1] = SCALE4[w[7:4]];
				scaled[2] = SCALE4[w[11:8]];
				scaled[3] = SCALE4[w[15:12]];
			end
			default: begin
				// Full 8888: bytes pass through and scale by a plain shift.
				dec_c.expanded[0] = w[7:0];
				dec_c.expanded[1] = w[15:8];
				dec_c.expanded[2] = w[23:16];
				dec_c.expanded[3] = w[31:24];
				scaled[0] = {w[7:0], 8'h00};
				scaled[1] = {w[15:8], 8'h00};
				scaled[2] = {w[23:16], 8'h00};
				scaled[3] = {w[31:24], 8'h00};
			end
		endcase
		// One signed multiplier per channel; the product is exact in 33 bits.
		wt_ext = PROD_W'(item_s1.morph_weight);
		for (int k = 0; k < 4; k++) begin
			sc_ext = PROD_W'($signed({1'b0, scaled[k]}));
			prod   = sc_ext * wt_ext;
			dec_c.product[k] = prod;
		end
	end

	assign s2_valid = valid_s2;
	assign s2_data  = data_s2;

endmodule

### hw/rtl/vcdm_accum.sv
// Blend stage: sums weighted products over the morph targets of a vertex,
// finishes the result, tracks the opaque flag and holds the output register.
// Depends on vcdm_pkg and vcdm_stream_if.
module vcdm_accum
	import vcdm_pkg::*;
#(
	parameter int MAX_MORPH_TARGETS = MAX_MORPH_TARGETS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [3:0]     morph_count,
	input  logic           vertex_clear,
	input  logic           s2_valid,
	input  decode_s2_t     s2_data,
	output logic           s2_ready,
	vcdm_stream_if.source  color_out
);

	localparam int CNT_W = (MAX_MORPH_TARGETS > 1) ? $clog2(MAX_MORPH_TARGETS) : 1;
	localparam int ACC_W = PROD_W + $clog2(MAX_MORPH_TARGETS);
	localparam logic [3:0] MAX_CNT = 4'(MAX_MORPH_TARGETS);

	logic [CNT_W-1:0]        cnt_q;
	logic [CNT_W:0]          cnt_inc;
	logic signed [ACC_W-1:0] acc_q [4];
	logic signed [ACC_W-1:0] sum_c [4];
	logic                    flag_q;
	logic                    flag_next;
	logic                    out_valid_q;
	color_out_t              out_data_q;
	color_out_t              res_c;
	logic [3:0]              n_eff;
	logic                    single;
	logic                    last;
	logic                    take_out;
	logic                    consume;

	// Sum to 8-bit channel: non-positive gives zero, otherwise integer part saturated.
	function automatic logic [7:0] finish(input logic signed [ACC_W-1:0] s);
		logic [7:0] r;
		if (s[ACC_W-1]) begin
			r = 8'h00;
		end else if (|s[ACC_W-2:FRAC_SHIFT+8]) begin
			r = OPAQUE;
		end else begin
			r = s[FRAC_SHIFT+7:FRAC_SHIFT];
		end
		return r;
	endfunction

	// Effective target count: zero acts as one, large values clip to the maximum.
	always_comb begin
		if (morph_count == 4'd0) begin
			n_eff = 4'd1;
		end else if (morph_count > MAX_CNT) begin
			n_eff = MAX_CNT;
		end else begin
			n_eff = morph_count;
		end
	end

	assign cnt_inc = {1'b0, cnt_q} + 1'b1;
	assign single  = (n_eff == 4'd1);
	assign last    = single || (4'(cnt_inc) == n_eff);

	// Running sums including the target now in the stage.
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			sum_c[k] = acc_q[k] + ACC_W'($signed(s2_data.product[k]));
		end
	end

	// Result and opaque flag for a finishing target.
	always_comb begin
		if (single) begin
			res_c.red   = s2_data.expanded[0];
			res_c.green = s2_data.expanded[1];
			res_c.blue  = s2_data.expanded[2];
			res_c.alpha = s2_data.expanded[3];
		end else begin
			res_c.red   = finish(sum_c[0]);
			res_c.green = finish(sum_c[1]);
			res_c.blue  = finish(sum_c[2]);
			res_c.alpha = s2_data.fmt565 ? OPAQUE : finish(sum_c[3]);
		end
		flag_next = s2_data.new_batch | flag_q;
		if (last && (res_c.alpha != OPAQUE)) begin
			flag_next = 1'b0;
		end
		res_c.full_alpha = flag_next;
	end

	// Intermediate targets never wait; a finishing one needs the output slot.
	assign take_out = !out_valid_q || color_out.ready;
	assign consume  = s2_valid && (!last || take_out);
	assign s2_ready = !s2_valid || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			flag_q      <= 1'b1;
			out_valid_q <= 1'b0;
			for (int k = 0; k < 4; k++) begin
				acc_q[k] <= '0;
			end
		end else begin
			if (vertex_clear) begin
				cnt_q <= '0;
				for (int k = 0; k < 4; k++) begin
					acc_q[k] <= '0;
				end
			end else if (consume) begin
				if (last) begin
					cnt_q <= '0;
					for (int k = 0; k < 4; k++) begin
						acc_q[k] <= '0;
					end
				end else begin
					cnt_q <= cnt_inc[CNT_W-1:0];
					for (int k = 0; k < 4; k++) begin
						acc_q[k] <= sum_c[k];
					end
				end
			end
			if (consume) begin
				flag_q <= flag_next;
			end
			if (consume && last) begin
				out_valid_q <= 1'b1;
			end else if (color_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (consume && last) begin
			out_data_q <= res_c;
		end
	end

	assign color_out.valid   = out_valid_q;
	assign color_out.payload = out_data_q;

endmodule

### hw/rtl/vcdm_checker.sv
// Port-level checks for the vertex color decoder, attached by bind.
// Depends on vcdm_pkg and the top level vertex_color_decode_morph.
module vcdm_checker
	import vcdm_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input color_out_t            out_payload,
	input logic                  psel,
	input logic                  penable,
	input logic                  pwrite,
	input logic [CFG_ADDR_W-1:0] paddr,
	input logic [CFG_DATA_W-1:0] pwdata,
	input logic [CFG_DATA_W-1:0] prdata
);

	// A stalled result stays offered and unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_payload))
	else $error("stalled result changed or was withdrawn");

	// The input side only pushes back while a result waits on a stalled receiver.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
	else $error("input stalled without a waiting result");

	// An input target that is pushed back stays offered until its transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid)
	else $error("input target withdrawn before its transfer");

	// A result that is not opaque can never report full alpha.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_payload.alpha != OPAQUE) |-> !out_payload.full_alpha)
	else $error("full_alpha set on a non-opaque result");

	// A register read right after a write to it returns the written bits.
	assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && !pwrite && $past(arst_n)
		&& $past(psel && penable && pwrite) && (paddr == $past(paddr))
		|-> prdata == (paddr[2] ? CFG_DATA_W'($past(pwdata[3:0]))
			: CFG_DATA_W'($past(pwdata[1:0]))))
	else $error("register read-back mismatch");

endmodule

bind vertex_color_decode_morph vcdm_checker u_vcdm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (color_in.valid),
	.in_ready    (color_in.ready),
	.out_valid   (color_out.valid),
	.out_ready   (color_out.ready),
	.out_payload (color_out.payload),
	.psel        (psel),
	.penable     (penable),
	.pwrite      (pwrite),
	.paddr       (paddr),
	.pwdata      (pwdata),
	.prdata      (prdata)
);

### tb/tb_vertex_color_decode_morph.sv
`timescale 1ns / 1ps
// Self-checking testbench for vertex_color_decode_morph: directed and random color targets.
// Depends on vcdm_pkg, vcdm_stream_if and the block's RTL; predicts every result in SystemVerilog.
module tb_vertex_color_decode_morph;
	import vcdm_pkg::*;

	localparam int          MAX_TARGETS   = 8;
	localparam int          PIPE_LATENCY  = 3;
	localparam int          SETTLE_CYCLES = PIPE_LATENCY + 5;
	localparam int          LIMIT_CYCLES  = 400000;
	localparam int          MAX_REPORTS   = 40;
	localparam int unsigned RANDOM_ITEMS  = 550;

	logic clk = 1'b0;
	logic arst_n;

	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	logic out_ready = 1'b0;

	vcdm_stream_if #(.payload_t(color_in_t))  color_in_if ();
	vcdm_stream_if #(.payload_t(color_out_t)) color_out_if ();

	assign color_out_if.ready = out_ready;

	vertex_color_decode_morph uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.color_in (color_in_if),
		.color_out(color_out_if),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// Clock with a 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Idle rates in percent of cycles for the sender and the receiver.
	int unsigned src_idle_pct  = 0;
	int unsigned sink_idle_pct = 0;
	int unsigned error_count   = 0;

	// Predicted decoder state and the results still to come.
	color_fmt_t  cur_fmt;
	logic [3:0]  cur_count;
	logic [2:0]  targets_seen;
	longint      blend_sum [4];
	bit          opaque_seen;
	color_out_t  expected_colors [$];

	// One line per mismatch; printing stops after a while but counting does not.
	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		if (error_count < MAX_REPORTS) begin
			$display("tb: mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		end
		error_count++;
	endtask

	// Bit replication of a narrow field to eight bits.
	function automatic logic [7:0] widen_field(int unsigned v, int unsigned m);
		case (m)
			31: return 8'((v << 3) | (v >> 2));
			63: return 8'((v << 2) | (v >> 4));
			15: return 8'(v * 17);
			1: return (v != 0) ? 8'hFF : 8'h00;
			default: return 8'(v);
		endcase
	endfunction

	// Unsigned 8.8 value of a field scaled to 0..255, halves rounded up.
	function automatic longint scaled_field(int unsigned v, int unsigned m);
		longint num;
		if (m == 255) return longint'(v) << 8;
		if (m == 1) return (v != 0) ? longint'(65280) : longint'(0);
		num = longint'(v) * 65280 + longint'(m / 2);
		return num / longint'(m);
	endfunction

	// Q.20 sum truncated to an integer and clamped to 0..255.
	function automatic logic [7:0] settle_sum(longint s);
		if (s <= 0) return 8'h00;
		if ((s >>> 20) > 255) return 8'hFF;
		return 8'(s >>> 20);
	endfunction

	task automatic clear_vertex();
		targets_seen = '0;
		for (int k = 0; k < 4; k++) begin
			blend_sum[k] = 0;
		end
	endtask

	// Decode one accepted target and queue the result it completes, if any.
	task automatic decode_and_blend(input color_in_t item);
		int unsigned field [4];
		int unsigned full [4];
		int unsigned depth;
		logic [31:0] w;
		longint      wt;
		color_out_t  res;
		w = item.color_word;
		wt = longint'($signed(item.morph_weight));
		depth = (cur_count == 0) ? 1 : ((cur_count > MAX_TARGETS) ? MAX_TARGETS : cur_count);
		if (item.new_batch) opaque_seen = 1'b1;

		case (cur_fmt)
			FMT_RGB565: begin
				field = '{w[4:0], w[10:5], w[15:11], 1};
				full = '{31, 63, 31, 1};
			end
			FMT_RGBA5551: begin
				field = '{w[4:0], w[9:5], w[14:10], w[15]};
				full = '{31, 31, 31, 1};
			end
			FMT_RGBA4444: begin
				field = '{w[3:0], w[7:4], w[11:8], w[15:12]};
				full = '{15, 15, 15, 15};
			end
			default: begin
				field = '{w[7:0], w[15:8], w[23:16], w[31:24]};
				full = '{255, 255, 255, 255};
			end
		endcase

		if (depth == 1) begin
			res.red = widen_field(field[0], full[0]);
			res.green = widen_field(field[1], full[1]);
			res.blue = widen_field(field[2], full[2]);
			res.alpha = widen_field(field[3], full[3]);
			clear_vertex();
		end else begin
			for (int k = 0; k < 4; k++) begin
				blend_sum[k] += scaled_field(field[k], full[k]) * wt;
			end
			targets_seen = targets_seen + 3'd1;
			if (targets_seen != 0 && targets_seen < depth) return;
			res.red = settle_sum(blend_sum[0]);
			res.green = settle_sum(blend_sum[1]);
			res.blue = settle_sum(blend_sum[2]);
			res.alpha = settle_sum(blend_sum[3]);
			if (cur_fmt == FMT_RGB565) res.alpha = 8'hFF;
			clear_vertex();
		end

		if (res.alpha != 8'hFF) opaque_seen = 1'b0;
		res.full_alpha = opaque_seen;
		expected_colors.push_back(res);
	endtask

	// Compare every result transfer with the oldest prediction.
	always @(posedge clk) begin : check_results
		color_out_t got;
		color_out_t want;
		if (arst_n && color_out_if.valid && out_ready) begin
			got = color_out_if.payload;
			if (expected_colors.size() == 0) begin
				report_mismatch("unexpected result", {got.red, got.green, got.blue, got.alpha}, 0);
			end else begin
				want = expected_colors.pop_front();
				if (got.red !== want.red) report_mismatch("red", got.red, want.red);
				if (got.green !== want.green) report_mismatch("green", got.green, want.green);
				if (got.blue !== want.blue) report_mismatch("blue", got.blue, want.blue);
				if (got.alpha !== want.alpha) report_mismatch("alpha", got.alpha, want.alpha);
				if (got.full_alpha !== want.full_alpha) begin
					report_mismatch("full_alpha", got.full_alpha, want.full_alpha);
				end
			end
		end
	end

	// Receiver stalls at the current rate.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= sink_idle_pct);
	end

	// Watchdog on the whole run.
	initial begin : watchdog
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("tb: failure");
		$finish;
	end

	// Send one target; valid stays high on return so back-to-back transfers work.
	task automatic send_target(input logic [31:0] word, input logic [15:0] weight,
			input logic batch);
		color_in_t item;
		item.color_word = word;
		item.morph_weight = weight;
		item.new_batch = batch;
		if ($urandom_range(99) < src_idle_pct) begin
			color_in_if.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		color_in_if.valid <= 1'b1;
		color_in_if.payload <= item;
		do @(posedge clk); while (!color_in_if.ready);
		decode_and_blend(item);
	endtask

	// Stop sending, wait for all results, then let a partial target settle.
	task automatic wait_idle();
		color_in_if.valid <= 1'b0;
		do @(posedge clk); while (expected_colors.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle until pready.
	task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CFG_ADDR_W'(int'(idx) * 4);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_COLOR_FORMAT) cur_fmt = color_fmt_t'(value[1:0]);
		else cur_count = value[3:0];
		clear_vertex();
	endtask

	task automatic set_config(input logic [31:0] fmt_value, input logic [31:0] count_value);
		wait_idle();
		write_reg(REG_COLOR_FORMAT, fmt_value);
		write_reg(REG_MORPH_COUNT, count_value);
	endtask

	// Single-target expansion in every format, with the field extremes.
	task automatic test_single_expand();
		set_config(FMT_RGB565, 1);
		send_target(32'h0000_0000, 16'h0000, 1'b0);
		send_target(32'h0000_FFFF, 16'h0000, 1'b0);
		send_target(32'hA5A5_F81F, 16'h8000, 1'b0);
		set_config(FMT_RGBA5551, 1);
		send_target(32'h0000_7FFF, 16'h0000, 1'b0);
		send_target(32'h0000_8000, 16'h7FFF, 1'b1);
		set_config(FMT_RGBA4444, 1);
		send_target(32'h0000_0FFF, 16'h0000, 1'b0);
		send_target(32'hFFFF_F000, 16'h0000, 1'b1);
		set_config(FMT_RGBA8888, 1);
		send_target(32'hFFFF_FFFF, 16'hFFFF, 1'b1);
		send_target(32'h0000_0000, 16'h0000, 1'b0);
	endtask

	// Weighted blends: plain, saturating, negative, and 565 with forced alpha.
	task automatic test_morph_blend();
		set_config(FMT_RGBA8888, 2);
		send_target(32'hFF80_4020, 16'h1000, 1'b1);
		send_target(32'h1020_4080, 16'h0800, 1'b0);
		send_target(32'hFFFF_FFFF, 16'h7FFF, 1'b0);
		send_target(32'hFFFF_FFFF, 16'h7FFF, 1'b0);
		set_config(FMT_RGB565, 3);
		send_target(32'h0000_FFFF, 16'h8000, 1'b0);
		send_target(32'h0000_1234, 16'h0555, 1'b0);
		send_target(32'h0000_FFFF, 16'h0555, 1'b0);
	endtask

	// Count of zero, count above the maximum, stray register bits, dropped vertex.
	task automatic test_count_limits();
		set_config(FMT_RGBA4444, 0);
		send_target(32'h0000_5A5A, 16'h0000, 1'b0);
		set_config(32'hFFFF_FFF9, 32'hFFFF_FFFF);
		for (int i = 0; i < MAX_TARGETS; i++) begin
			send_target($urandom, 16'h0200, 1'b0);
		end
		set_config(FMT_RGBA8888, 2);
		send_target(32'hFFFF_FFFF, 16'h7FFF, 1'b0);
		set_config(FMT_RGBA8888, 2);
		send_target(32'h8040_2010, 16'h1000, 1'b1);
		send_target(32'h0102_0408, 16'h0400, 1'b0);
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(7))
			0: return 32'hFFFF_FFFF;
			1: return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	// Weights mostly in a range that keeps blends away from the clamps.
	function automatic logic [15:0] pick_weight(int unsigned depth);
		case ($urandom_range(9))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3, 4: return 16'($urandom_range(65535));
			5: return 16'(-int'($urandom_range(2048)));
			default: return 16'($urandom_range(8192 / depth));
		endcase
	endfunction

	function automatic logic [3:0] pick_count();
		case ($urandom_range(9))
			0: return 4'd1;
			1: return 4'd2;
			2: return 4'd8;
			3: return 4'd0;
			4: return 4'($urandom_range(15, 9));
			default: return 4'($urandom_range(8, 1));
		endcase
	endfunction

	// Random blocks of whole vertices under random settings, some left unfinished.
	task automatic test_random_stream(input int unsigned src_pct, input int unsigned sink_pct,
			input int unsigned n_items);
		int unsigned sent;
		int unsigned depth;
		int unsigned vertices;
		logic [31:0] fmt_value;
		logic [31:0] count_value;
		src_idle_pct = src_pct;
		sink_idle_pct = sink_pct;
		sent = 0;
		while (sent < n_items) begin
			fmt_value = $urandom_range(3);
			count_value = 32'(pick_count());
			if ($urandom_range(9) == 0) begin
				fmt_value[31:2] = 30'($urandom);
				count_value[31:4] = 28'($urandom);
			end
			set_config(fmt_value, count_value);
			depth = (cur_count == 0) ? 1 : ((cur_count > MAX_TARGETS) ? MAX_TARGETS : cur_count);
			vertices = $urandom_range(20, 4);
			for (int v = 0; v < vertices; v++) begin
				for (int t = 0; t < depth; t++) begin
					send_target(pick_word(), pick_weight(depth), $urandom_range(19) == 0);
					sent++;
				end
			end
			// Now and then leave a vertex half done for the next write to drop.
			if (depth > 1 && $urandom_range(4) == 0) begin
				for (int t = 0; t < $urandom_range(depth - 1, 1); t++) begin
					send_target(pick_word(), pick_weight(depth), 1'b0);
					sent++;
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		color_in_if.valid <= 1'b0;
		color_in_if.payload <= '0;
		cur_fmt = FMT_RGB565;
		cur_count = 4'd1;
		opaque_seen = 1'b1;
		clear_vertex();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct = 20;
		sink_idle_pct = 46;
		test_single_expand();
		test_morph_blend();
		test_count_limits();
		test_random_stream(20, 46, RANDOM_ITEMS);
		test_random_stream(46, 20, RANDOM_ITEMS);
		test_random_stream(0, 0, RANDOM_ITEMS);
		wait_idle();

		if (error_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
